>>> rtl/dbam_pkg.sv
// Shared types, codes and constants of the directory allocation map.
`default_nettype none
package dbam_pkg;

  // Default sizes of the directory and the block map.
  localparam int DBAM_EXTENTS  = 32;
  localparam int DBAM_BLOCKS   = 256;
  localparam int DBAM_POINTERS = 16;

  // Layout of one 32-byte extent.
  localparam int EXT_BYTES  = 32;
  localparam int STATUS_POS = 0;
  localparam int BC_POS     = 13;
  localparam int RC_POS     = 15;
  localparam int PTR_BASE   = 16;

  localparam logic [7:0] DEAD_MARK = 8'hE5;

  // File length: one block is 1024 bytes, one record 128 bytes.
  localparam int BLOCK_SHIFT  = 10;
  localparam int RECORD_SHIFT = 7;

  // Depth of the command queue between the front and the back end.
  localparam int QUEUE_DEPTH = 4;

  // Result kinds.
  localparam logic [1:0] RES_LISTING = 2'd0;
  localparam logic [1:0] RES_QUERY   = 2'd1;
  localparam logic [1:0] RES_DELETE  = 2'd2;

  // Item kinds.
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_REBUILD = 2'd1,
    OP_QUERY   = 2'd2,
    OP_DELETE  = 2'd3
  } op_t;

  // One command as it travels through the queue.
  typedef struct packed {
    op_t        op;
    logic [9:0] offset;
    logic [7:0] data;
    logic [7:0] block;
    logic [4:0] sel;
  } cmd_t;

endpackage
`default_nettype wire

>>> rtl/dbam_if.sv
// Valid/ready channel interfaces for items and results.
`default_nettype none
interface dbam_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [9:0] dir_offset;
  logic [7:0] dir_byte;
  logic [7:0] query_blk;
  logic [4:0] extent_select;

  modport source (output valid, kind, dir_offset, dir_byte, query_blk, extent_select,
                  input ready);
  modport sink (input valid, kind, dir_offset, dir_byte, query_blk, extent_select,
                output ready);
endinterface

interface dbam_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic [4:0]         extent_index;
  logic [7:0]         status_byte;
  logic               live;
  logic [4:0]         used_pointers;
  logic signed [16:0] len_bytes;
  logic               block_free;
  logic               last;

  modport source (output valid, result_kind, extent_index, status_byte, live,
                  used_pointers, len_bytes, block_free, last,
                  input ready);
  modport sink (input valid, result_kind, extent_index, status_byte, live,
                used_pointers, len_bytes, block_free, last,
                output ready);
endinterface
`default_nettype wire

>>> rtl/dbam_front.sv
// Front end: accepts items, drops those without effect and queues the rest.
`default_nettype none
module dbam_front #(
  parameter int EXTENTS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  dbam_in_if.sink            in_chan,
  output dbam_pkg::cmd_t     cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_ready
);
  import dbam_pkg::*;

  localparam int DIR_BYTES = EXTENTS * EXT_BYTES;
  localparam int QAW       = $clog2(QUEUE_DEPTH);
  localparam logic [QAW:0] FULL = (QAW + 1)'(QUEUE_DEPTH);

  cmd_t           q_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   cnt_r;
  cmd_t           in_cmd;
  logic           keep;
  logic           push;
  logic           pop;

  // Classify the incoming transaction; out-of-range loads and deletes change nothing.
  always_comb begin
    in_cmd.op     = op_t'(in_chan.kind);
    in_cmd.offset = in_chan.dir_offset;
    in_cmd.data   = in_chan.dir_byte;
    in_cmd.block  = in_chan.query_blk;
    in_cmd.sel    = in_chan.extent_select;
    keep = 1'b1;
    if (in_cmd.op == OP_LOAD && 12'(in_cmd.offset) >= 12'(DIR_BYTES)) begin
      keep = 1'b0;
    end
    if (in_cmd.op == OP_DELETE && 7'(in_cmd.sel) >= 7'(EXTENTS)) begin
      keep = 1'b0;
    end
  end

  assign in_chan.ready = (cnt_r != FULL);
  assign push          = in_chan.valid && in_chan.ready && keep;
  assign cmd_valid     = (cnt_r != '0);
  assign pop           = cmd_valid && cmd_ready;
  assign cmd           = q_r[rd_ptr_r];

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule
`default_nettype wire

>>> rtl/dbam_back.sv
// Back end: directory memory, free map and the sequencer that executes commands.
`default_nettype none
module dbam_back #(
  parameter int EXTENTS             = 32,
  parameter int BLOCKS              = 256,
  parameter int POINTERS_PER_EXTENT = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire dbam_pkg::cmd_t cmd,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  dbam_out_if.source          out_chan
);
  import dbam_pkg::*;

  localparam int DIR_BYTES = EXTENTS * EXT_BYTES;
  localparam int AW        = $clog2(DIR_BYTES);
  localparam int EW        = (EXTENTS > 1) ? $clog2(EXTENTS) : 1;
  localparam int BW        = $clog2(BLOCKS);
  localparam int NS        = 3 + POINTERS_PER_EXTENT;
  localparam int SW        = $clog2(NS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RB_RD,
    S_RB_WAIT,
    S_RB_EMIT,
    S_DEL_RD,
    S_DEL_WAIT,
    S_DEL_EMIT
  } state_t;

  // Offset inside an extent of each read step of a rebuild.
  function automatic logic [4:0] rb_offset(input logic [SW-1:0] s);
    logic [4:0] o;
    if (s == SW'(0)) begin
      o = 5'(STATUS_POS);
    end else if (s == SW'(1)) begin
      o = 5'(BC_POS);
    end else if (s == SW'(2)) begin
      o = 5'(RC_POS);
    end else begin
      o = 5'(s) + 5'(PTR_BASE - 3);
    end
    return o;
  endfunction

  logic [7:0]        mem [DIR_BYTES];
  logic [7:0]        rd_data_r;
  logic [BLOCKS-1:0] free_map_r;
  logic [BLOCKS-1:0] free_nxt;

  state_t            state_r;
  logic [EW-1:0]     ext_r;
  logic [SW-1:0]     step_r;
  logic              rd_vld_r;
  logic              rd_del_r;
  logic [SW-1:0]     rd_step_r;
  logic [AW-1:0]     rd_addr_r;
  logic [7:0]        status_r;
  logic [7:0]        bc_r;
  logic [7:0]        rc_r;
  logic [4:0]        used_r;

  logic              out_valid_r;
  logic [1:0]        out_kind_r;
  logic [4:0]        out_ext_r;
  logic [7:0]        out_status_r;
  logic              out_live_r;
  logic [4:0]        out_used_r;
  logic [16:0]       out_len_r;
  logic              out_free_r;
  logic              out_last_r;

  logic              out_open;
  logic              take;
  logic              query_free;
  logic              ptr_hit;
  logic [4:0]        step_off;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [7:0]        wr_data;
  logic [16:0]       length;

  assign out_open  = !out_valid_r || out_chan.ready;
  assign cmd_ready = (state_r == S_IDLE) && (cmd.op != OP_QUERY || out_open);
  assign take      = cmd_valid && cmd_ready;

  assign query_free = (9'(cmd.block) < 9'(BLOCKS)) && free_map_r[BW'(cmd.block)];
  assign ptr_hit    = (rd_data_r != 8'd0) && (9'(rd_data_r) < 9'(BLOCKS));

  // File length of the extent just walked, in 17-bit two's complement.
  assign length = (17'(used_r) << BLOCK_SHIFT) - (17'd1 << BLOCK_SHIFT)
                + (17'(rc_r) << RECORD_SHIFT) + 17'(bc_r);

  // Memory port control: reads follow the step counter, writes come from
  // loads, the delete mark and the pointer clearing of a delete.
  always_comb begin
    if (state_r == S_DEL_RD) begin
      step_off = 5'(step_r) + 5'(PTR_BASE);
    end else begin
      step_off = rb_offset(step_r);
    end
    rd_addr = AW'({ext_r, step_off});
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (take && cmd.op == OP_LOAD) begin
      wr_en   = 1'b1;
      wr_addr = AW'(cmd.offset);
      wr_data = cmd.data;
    end else if (take && cmd.op == OP_DELETE) begin
      wr_en   = 1'b1;
      wr_addr = AW'({EW'(cmd.sel), 5'(STATUS_POS)});
      wr_data = DEAD_MARK;
    end else if (rd_vld_r && rd_del_r) begin
      wr_en   = 1'b1;
      wr_addr = rd_addr_r;
      wr_data = 8'd0;
    end
  end

  // Directory memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Free map updates: a rebuild frees all but block 0, then pointers mark or free.
  always_comb begin
    free_nxt = free_map_r;
    if (take && cmd.op == OP_REBUILD) begin
      free_nxt = {{(BLOCKS - 1){1'b1}}, 1'b0};
    end
    if (rd_vld_r && ptr_hit && (rd_del_r || rd_step_r >= SW'(3))) begin
      free_nxt[BW'(rd_data_r)] = rd_del_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_map_r <= {{(BLOCKS - 1){1'b1}}, 1'b0};
    end else begin
      free_map_r <= free_nxt;
    end
  end

  // Sequencer with the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= 1'b0;
      if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            unique case (cmd.op)
              OP_LOAD: begin
              end
              OP_REBUILD: begin
                ext_r   <= '0;
                step_r  <= '0;
                state_r <= S_RB_RD;
              end
              OP_QUERY: begin
                out_valid_r  <= 1'b1;
                out_kind_r   <= RES_QUERY;
                out_ext_r    <= '0;
                out_status_r <= '0;
                out_live_r   <= 1'b0;
                out_used_r   <= '0;
                out_len_r    <= '0;
                out_free_r   <= query_free;
                out_last_r   <= 1'b1;
              end
              OP_DELETE: begin
                ext_r   <= EW'(cmd.sel);
                step_r  <= '0;
                state_r <= S_DEL_RD;
              end
            endcase
          end
        end
        S_RB_RD: begin
          rd_vld_r  <= 1'b1;
          rd_del_r  <= 1'b0;
          rd_step_r <= step_r;
          step_r    <= step_r + 1'b1;
          if (step_r == '0) begin
            used_r <= '0;
          end
          if (step_r == SW'(NS - 1)) begin
            state_r <= S_RB_WAIT;
          end
        end
        S_RB_WAIT: begin
          state_r <= S_RB_EMIT;
        end
        S_RB_EMIT: begin
          if (out_open) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= RES_LISTING;
            out_ext_r    <= 5'(ext_r);
            out_status_r <= status_r;
            out_live_r   <= (status_r != DEAD_MARK);
            out_used_r   <= used_r;
            out_len_r    <= length;
            out_free_r   <= 1'b0;
            out_last_r   <= (ext_r == EW'(EXTENTS - 1));
            if (ext_r == EW'(EXTENTS - 1)) begin
              state_r <= S_IDLE;
            end else begin
              ext_r   <= ext_r + 1'b1;
              step_r  <= '0;
              state_r <= S_RB_RD;
            end
          end
        end
        S_DEL_RD: begin
          rd_vld_r  <= 1'b1;
          rd_del_r  <= 1'b1;
          rd_step_r <= step_r;
          rd_addr_r <= rd_addr;
          step_r    <= step_r + 1'b1;
          if (step_r == SW'(POINTERS_PER_EXTENT - 1)) begin
            state_r <= S_DEL_WAIT;
          end
        end
        S_DEL_WAIT: begin
          state_r <= S_DEL_EMIT;
        end
        S_DEL_EMIT: begin
          if (out_open) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= RES_DELETE;
            out_ext_r    <= 5'(ext_r);
            out_status_r <= DEAD_MARK;
            out_live_r   <= 1'b0;
            out_used_r   <= '0;
            out_len_r    <= '0;
            out_free_r   <= 1'b0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      // Capture the fields of an extent as its bytes come back during a rebuild.
      if (rd_vld_r && !rd_del_r) begin
        if (rd_step_r == SW'(0)) begin
          status_r <= rd_data_r;
        end else if (rd_step_r == SW'(1)) begin
          bc_r <= rd_data_r;
        end else if (rd_step_r == SW'(2)) begin
          rc_r <= rd_data_r;
        end else if (rd_data_r != 8'd0) begin
          used_r <= used_r + 1'b1;
        end
      end
    end
  end

  // Result channel.
  assign out_chan.valid         = out_valid_r;
  assign out_chan.result_kind   = out_kind_r;
  assign out_chan.extent_index  = out_ext_r;
  assign out_chan.status_byte   = out_status_r;
  assign out_chan.live          = out_live_r;
  assign out_chan.used_pointers = out_used_r;
  assign out_chan.len_bytes     = $signed(out_len_r);
  assign out_chan.block_free    = out_free_r;
  assign out_chan.last          = out_last_r;

endmodule
`default_nettype wire

>>> rtl/directory_block_allocation_map_unit.sv
// Top level of the directory allocation map: front end, command queue and back end.
//
// Usage: items arrive on in_chan (valid/ready). A load writes one directory byte
// and gives no result; a query returns one result with the free bit of a block;
// a rebuild recomputes the free map and returns one listing per extent, the
// final one flagged last; a delete marks an extent dead, frees its blocks and
// returns one result. Results leave on out_chan (valid/ready) from one register.
// Items pass a four-entry queue, so the input keeps taking transactions while
// the back end works or the receiver stalls until the queue is full; a stalled
// result holds its value. Loads and queries finish in the back end's idle state,
// so loads stream at one per cycle while no rebuild or delete runs; a query
// waits until the output register is free, then its result is registered there.
// A rebuild walks the directory memory through its single read port, reading
// POINTERS_PER_EXTENT + 3 bytes per extent; a stall on out_chan holds it before
// each listing. A delete reads and clears the POINTERS_PER_EXTENT pointer bytes
// of its extent in turn, then returns its result when out_chan can take it.
// Reset empties the queue and the output register and sets every block free
// except block 0; the directory contents are undefined until loaded.
`default_nettype none
module directory_block_allocation_map_unit #(
  parameter int EXTENTS             = dbam_pkg::DBAM_EXTENTS,
  parameter int BLOCKS              = dbam_pkg::DBAM_BLOCKS,
  parameter int POINTERS_PER_EXTENT = dbam_pkg::DBAM_POINTERS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  dbam_in_if.sink   in_chan,
  dbam_out_if.source out_chan
);
  import dbam_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  dbam_front #(
    .EXTENTS(EXTENTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cmd      (cmd),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready)
  );

  dbam_back #(
    .EXTENTS            (EXTENTS),
    .BLOCKS             (BLOCKS),
    .POINTERS_PER_EXTENT(POINTERS_PER_EXTENT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire
